[src/lfba_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and codes for the lowest-free block allocator.
package lfba_pkg;

  localparam int NUM_BLOCKS = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int ROW_W      = 8;
  localparam int ROWS       = NUM_BLOCKS / ROW_W;
  localparam int ROW_AW     = $clog2(ROWS);
  localparam int BIT_AW     = $clog2(ROW_W);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NOT_ALLOC  = 2'd2,
    ST_CHECK_FREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_FIND
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
    logic [ROW_W-1:0]  data;
  } row_wr_t;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
  } row_rd_t;

endpackage

[src/lowest_free_block_allocator.sv]
`timescale 1ns / 1ps
// Lowest-free block allocator: bitmap of used blocks held in a row memory.
// One word at a time: free, check, no-op and pool-full allocate words give their result
// after a row read, a granting allocate after row read, write back, read of the lowest
// non-full row and bit search, or after the write back when it takes the last free
// block. A new word is taken only once the last one has given its result, even while a
// result waits unsent. Synchronous reset clears all control state and row valid flags.
module lowest_free_block_allocator
  import lfba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       operation,
  input  logic [IDX_W-1:0] block_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic [IDX_W-1:0] granted_index,
  output logic [CNT_W-1:0] allocated_count,
  output logic             has_free
);

  state_t            state, state_next;
  op_t               op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  grant_q, grant_next;
  logic [ROW_AW-1:0] row_q;
  logic [IDX_W-1:0]  hint, hint_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              free_avail, free_next;

  row_wr_t           wr;
  row_rd_t           rd;
  logic [ROW_W-1:0]  rd_data;
  logic [ROWS-1:0]   row_full;

  logic              out_free;
  logic              load;
  status_t           res_status;
  logic [IDX_W-1:0]  res_grant;

  logic              srch_any;
  logic [ROW_AW-1:0] srch_row;
  logic [BIT_AW-1:0] zero_bit;
  logic              cur_bit;

  lfba_row_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd       (rd),
    .rd_data  (rd_data),
    .row_full (row_full)
  );

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  assign cur_bit  = rd_data[idx_q[BIT_AW-1:0]];

  // Lowest row that still has a free block.
  always_comb begin
    srch_any = 1'b0;
    srch_row = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (!row_full[i]) begin
        srch_any = 1'b1;
        srch_row = ROW_AW'(i);
      end
    end
  end

  // Lowest free block within the row just read.
  always_comb begin
    zero_bit = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (!rd_data[i]) begin
        zero_bit = BIT_AW'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          if (op_q == OP_ALLOC && free_avail) state_next = S_SEARCH;
          else state_next = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (srch_any) state_next = S_FIND;
        else if (out_free) state_next = S_IDLE;
      end
      S_FIND: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    wr         = '0;
    rd         = '0;
    hint_next  = hint;
    count_next = count;
    free_next  = free_avail;
    grant_next = grant_q;
    load       = 1'b0;
    res_status = ST_OK;
    res_grant  = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          rd.en   = 1'b1;
          rd.addr = (op_t'(operation) == OP_ALLOC) ? hint[BIT_AW +: ROW_AW]
                                                   : block_index[BIT_AW +: ROW_AW];
        end
      end
      S_EXEC: begin
        if (out_free) begin
          unique case (op_q)
            OP_ALLOC: begin
              if (!free_avail) begin
                load       = 1'b1;
                res_status = ST_FULL;
              end else begin
                wr.en      = 1'b1;
                wr.addr    = hint[BIT_AW +: ROW_AW];
                wr.data    = rd_data | (ROW_W'(1) << hint[BIT_AW-1:0]);
                count_next = count + CNT_W'(1);
                grant_next = hint;
              end
            end
            OP_FREE: begin
              load = 1'b1;
              if (cur_bit) begin
                wr.en   = 1'b1;
                wr.addr = idx_q[BIT_AW +: ROW_AW];
                wr.data = rd_data & ~(ROW_W'(1) << idx_q[BIT_AW-1:0]);
                if (count != '0) count_next = count - CNT_W'(1);
                if (!free_avail || idx_q < hint) hint_next = idx_q;
                free_next = 1'b1;
              end else begin
                res_status = ST_NOT_ALLOC;
              end
            end
            OP_CHECK: begin
              load       = 1'b1;
              res_status = cur_bit ? ST_OK : ST_CHECK_FREE;
            end
            OP_NOP: begin
              load = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        if (srch_any) begin
          rd.en   = 1'b1;
          rd.addr = srch_row;
        end else if (out_free) begin
          // The last free block was just granted.
          free_next = 1'b0;
          hint_next = '0;
          load      = 1'b1;
          res_grant = grant_q;
        end
      end
      S_FIND: begin
        if (out_free) begin
          hint_next = {row_q, zero_bit};
          load      = 1'b1;
          res_grant = grant_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hint       <= '0;
      count      <= '0;
      free_avail <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      hint       <= hint_next;
      count      <= count_next;
      free_avail <= free_next;
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_q  <= op_t'(operation);
      idx_q <= block_index;
    end
    grant_q <= grant_next;
    if (state == S_SEARCH) row_q <= srch_row;
    if (load) begin
      status          <= res_status;
      granted_index   <= res_grant;
      allocated_count <= count_next;
      has_free        <= free_next;
    end
  end

endmodule

[src/lfba_row_store.sv]
`timescale 1ns / 1ps
// Used-map row memory with per-row valid and full flags.
module lfba_row_store
  import lfba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  row_wr_t          wr,
  input  row_rd_t          rd,
  output logic [ROW_W-1:0] rd_data,
  output logic [ROWS-1:0]  row_full
);

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROW_W-1:0] rd_raw;
  logic [ROWS-1:0]  row_valid;
  logic             rd_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_raw <= mem[rd.addr];
    end
  end

  // A row never written since reset reads as all free.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      row_full  <= '0;
      rd_hit    <= 1'b0;
    end else begin
      if (wr.en) begin
        row_valid[wr.addr] <= 1'b1;
        row_full[wr.addr]  <= &wr.data;
      end
      if (rd.en) begin
        rd_hit <= row_valid[rd.addr];
      end
    end
  end

  assign rd_data = rd_hit ? rd_raw : '0;

endmodule

[src/lfba_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the lowest-free block allocator, bound to the top level.
module lfba_checker
  import lfba_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic [1:0]       operation,
  input logic [IDX_W-1:0] block_index,
  input logic             out_valid,
  input logic             out_stall,
  input logic [1:0]       status,
  input logic [IDX_W-1:0] granted_index,
  input logic [CNT_W-1:0] allocated_count,
  input logic             has_free
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(granted_index)
      && $stable(allocated_count) && $stable(has_free))
    else $error("stalled result word changed");

  // Only a successful allocate reports a granted block.
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> granted_index == '0)
    else $error("granted index set on a failed operation");

  // A full pool reports no free block and a full count.
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> !has_free && allocated_count == CNT_W'(NUM_BLOCKS))
    else $error("pool full reported while blocks remain");

  // The free flag and the count agree.
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (has_free == (allocated_count != CNT_W'(NUM_BLOCKS))))
    else $error("free flag disagrees with allocated count");

  // No word is accepted before the previous one has been turned into a result.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while one is in progress");

endmodule

bind lowest_free_block_allocator lfba_checker u_lfba_checker (.*);

[test/lowest_free_block_allocator_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the lowest-free block allocator: directed table, random phases.
module lowest_free_block_allocator_tb;
  import lfba_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 12;
  localparam int PHASE_WORDS    = 158;
  localparam int PLAN_ROWS      = 18;
  localparam int DRAIN_CYCLES   = 10;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_UNIFORM
  } mix_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] granted;
    logic [CNT_W-1:0] count;
    logic             has_free;
  } alloc_result_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic             typed;
    alloc_result_t    want;
  } plan_row_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       operation;
  logic [IDX_W-1:0] block_index;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       status;
  logic [IDX_W-1:0] granted_index;
  logic [CNT_W-1:0] allocated_count;
  logic             has_free;

  // Shadow copy of the allocator's bookkeeping.
  logic [NUM_BLOCKS-1:0] pool_used;
  int                    pool_hint;
  int                    pool_count;
  bit                    pool_has_free;

  alloc_result_t pending_results[$];
  int            errors;
  int            checked;
  int            op_seen[4];
  int            full_seen;
  int            peak_count;
  int            idle_cycles;
  bit            gaps_on;
  bit            stalls_on;

  // Rows with typed set carry a result that follows directly from their place after reset.
  plan_row_t plan [PLAN_ROWS] = '{
    '{OP_CHECK, 6'd0,  1'b1, '{ST_CHECK_FREE, 6'd0, 7'd0, 1'b1}},
    '{OP_FREE,  6'd63, 1'b1, '{ST_NOT_ALLOC,  6'd0, 7'd0, 1'b1}},
    '{OP_NOP,   6'd63, 1'b1, '{ST_OK,         6'd0, 7'd0, 1'b1}},
    '{OP_ALLOC, 6'd0,  1'b1, '{ST_OK,         6'd0, 7'd1, 1'b1}},
    '{OP_ALLOC, 6'd63, 1'b1, '{ST_OK,         6'd1, 7'd2, 1'b1}},
    '{OP_CHECK, 6'd1,  1'b1, '{ST_OK,         6'd0, 7'd2, 1'b1}},
    '{OP_FREE,  6'd0,  1'b1, '{ST_OK,         6'd0, 7'd1, 1'b1}},
    '{OP_FREE,  6'd0,  1'b1, '{ST_NOT_ALLOC,  6'd0, 7'd1, 1'b1}},
    '{OP_CHECK, 6'd0,  1'b1, '{ST_CHECK_FREE, 6'd0, 7'd1, 1'b1}},
    '{OP_ALLOC, 6'd21, 1'b1, '{ST_OK,         6'd0, 7'd2, 1'b1}},
    '{OP_ALLOC, 6'd42, 1'b1, '{ST_OK,         6'd2, 7'd3, 1'b1}},
    '{OP_FREE,  6'd1,  1'b1, '{ST_OK,         6'd0, 7'd2, 1'b1}},
    '{OP_CHECK, 6'd63, 1'b1, '{ST_CHECK_FREE, 6'd0, 7'd2, 1'b1}},
    '{OP_ALLOC, 6'd0,  1'b1, '{ST_OK,         6'd1, 7'd3, 1'b1}},
    '{OP_FREE,  6'd2,  1'b0, '0},
    '{OP_FREE,  6'd1,  1'b0, '0},
    '{OP_FREE,  6'd0,  1'b0, '0},
    '{OP_NOP,   6'd42, 1'b0, '0}
  };

  lowest_free_block_allocator dut (.*);

  always #1 clk = ~clk;

  function automatic int lowest_free_block();
    for (int i = 0; i < NUM_BLOCKS; i++)
      if (!pool_used[i]) return i;
    pool_has_free = 1'b0;
    return 0;
  endfunction

  function automatic alloc_result_t predict_word(op_t op, logic [IDX_W-1:0] idx);
    alloc_result_t r;
    int            i;
    r = '0;
    r.status = ST_OK;
    i = int'(idx);
    case (op)
      OP_ALLOC: begin
        if (!pool_has_free || pool_hint >= NUM_BLOCKS) begin
          r.status = ST_FULL;
        end else begin
          r.granted = pool_hint[IDX_W-1:0];
          pool_used[pool_hint] = 1'b1;
          pool_count++;
          pool_hint = lowest_free_block();
        end
      end
      OP_FREE: begin
        if (i >= NUM_BLOCKS || !pool_used[i]) begin
          r.status = ST_NOT_ALLOC;
        end else begin
          pool_used[i] = 1'b0;
          if (pool_count > 0) pool_count--;
          // A free on a full pool, or below the hint, moves the hint to the freed block.
          if (!pool_has_free || i < pool_hint) pool_hint = i;
          pool_has_free = 1'b1;
        end
      end
      OP_CHECK: begin
        if (i >= NUM_BLOCKS || !pool_used[i]) r.status = ST_CHECK_FREE;
      end
      default: ;
    endcase
    r.count    = pool_count[CNT_W-1:0];
    r.has_free = pool_has_free;
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pick_used_block();
    int start;
    int k;
    start = $urandom_range(0, NUM_BLOCKS - 1);
    for (k = 0; k < NUM_BLOCKS; k++)
      if (pool_used[(start + k) % NUM_BLOCKS]) return IDX_W'((start + k) % NUM_BLOCKS);
    return IDX_W'(start);
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic offer_word(op_t op, logic [IDX_W-1:0] idx, logic typed, alloc_result_t want);
    alloc_result_t predicted;
    int            gap;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation   = op;
    block_index = idx;
    in_valid    = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_word(op, idx);
    pending_results.push_back(typed ? want : predicted);
    op_seen[int'(op)]++;
    if (predicted.status == ST_FULL) full_seen++;
    if (pool_count > peak_count) peak_count = pool_count;
  endtask

  task automatic run_phase(mix_t mix, int words);
    int               n;
    int               roll;
    op_t              op;
    logic [IDX_W-1:0] idx;
    for (n = 0; n < words; n++) begin
      roll = $urandom_range(0, 99);
      idx  = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
      case (mix)
        MIX_FILL:
          op = roll < 80 ? OP_ALLOC : roll < 90 ? OP_FREE : roll < 96 ? OP_CHECK : OP_NOP;
        MIX_DRAIN:
          op = roll < 75 ? OP_FREE : roll < 85 ? OP_ALLOC : roll < 96 ? OP_CHECK : OP_NOP;
        default:
          op = op_t'($urandom_range(0, 3));
      endcase
      // Most frees and checks name a block in use, so they get past the not-allocated path.
      if ((op == OP_FREE || op == OP_CHECK) && $urandom_range(0, 3) != 0)
        idx = pick_used_block();
      offer_word(op, idx, 1'b0, '0);
    end
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    alloc_result_t want;
    int            hold;
    wait (!rst);
    forever begin
      hold = stalls_on ? $urandom_range(0, 15) : 0;
      @(negedge clk);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      checked++;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected word, status", int'(status), 0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          flag_mismatch("status", int'(status), int'(want.status));
        if (granted_index !== want.granted)
          flag_mismatch("granted_index", int'(granted_index), int'(want.granted));
        if (allocated_count !== want.count)
          flag_mismatch("allocated_count", int'(allocated_count), int'(want.count));
        if (has_free !== want.has_free)
          flag_mismatch("has_free", int'(has_free), int'(want.has_free));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    operation     = OP_NOP;
    block_index   = '0;
    out_stall     = 1'b0;
    pool_used     = '0;
    pool_hint     = 0;
    pool_count    = 0;
    pool_has_free = 1'b1;
    errors        = 0;
    checked       = 0;
    full_seen     = 0;
    peak_count    = 0;
    idle_cycles   = 0;
    op_seen       = '{0, 0, 0, 0};
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < PLAN_ROWS; r++)
      offer_word(plan[r].op, plan[r].idx, plan[r].typed, plan[r].want);
    @(negedge clk);
    in_valid = 1'b0;
    wait_for_results();

    // Fill, drain and uniform phases in turn; the sender waits for all results after each.
    for (int p = 0; p < PHASES; p++) begin
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      run_phase(mix_t'(p % 3), PHASE_WORDS);
      @(negedge clk);
      in_valid = 1'b0;
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d allocate, %0d free, %0d check and %0d no-op words; %0d checked.",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3], checked);
    $display("Pool-full answers: %0d, peak allocated count: %0d, mismatches: %0d.",
             full_seen, peak_count, errors);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
src/lfba_pkg.sv
src/lfba_row_store.sv
src/lowest_free_block_allocator.sv
src/lfba_checker.sv
test/lowest_free_block_allocator_tb.sv
